// ===== rtl/rsb_pkg.sv =====
// Shared types, constants and arithmetic helpers for the radial spectrum binning unit.
// No dependencies; every other file imports this package.
package rsb_pkg;

  localparam int BIN_COUNT = 256;
  localparam int BIN_AW    = $clog2(BIN_COUNT);
  localparam int K2W       = 2 * BIN_AW;
  localparam int BIN_LIMIT = BIN_COUNT * BIN_COUNT;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 32;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_MODE       = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_GRID_LEN   = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_SLAB_DEPTH = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_SLAB_BASE  = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_MASS       = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_K_SCALE    = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_NORM       = 3'd6;

  // weighting modes
  localparam logic [2:0] MODE_KINETIC  = 3'd0;
  localparam logic [2:0] MODE_POWER    = 3'd1;
  localparam logic [2:0] MODE_GRAD     = 3'd2;
  localparam logic [2:0] MODE_GRAD_NOK = 3'd3;
  localparam logic [2:0] MODE_POT      = 3'd4;
  localparam logic [2:0] MODE_GRAD_POT = 3'd5;
  localparam logic [2:0] MODE_COUNT    = 3'd6;

  typedef enum logic [1:0] {
    OP_ACCUM = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DIV_X,
    S_DIV_Y,
    S_SQ,
    S_CHK,
    S_SQRT_BIN,
    S_MAG,
    S_DBL,
    S_KSC,
    S_ROOTW,
    S_SQRT_W,
    S_MW,
    S_DIV_W,
    S_PICK,
    S_MUL_K,
    S_KEND,
    S_MUL_M,
    S_MEND,
    S_WRITE,
    S_NRM_M,
    S_NRM_MEND,
    S_NRM_X,
    S_NRM_XEND,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic        start;
    logic [6:0]  steps;
    logic [31:0] rem_init;
    logic [31:0] den;
    logic [63:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic        start;
    logic [63:0] radicand;
  } sqrt_req_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  // full product to Q16.16 scaled result, saturated
  function automatic logic [63:0] q16_sat(input logic [127:0] p);
    return (|p[127:80]) ? '1 : p[79:16];
  endfunction

endpackage

// ===== rtl/rsb_if.sv =====
// Valid/ready channel interfaces for the input and result items.
// Depends on rsb_pkg (none of its items are needed at present beyond the import).
interface rsb_in_if;
  import rsb_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [26:0] position;
  logic signed [31:0] coef_re;
  logic signed [31:0] coef_im;
  logic [7:0]  bin_select;
  modport source (output valid, operation, position, coef_re, coef_im, bin_select,
                  input ready);
  modport sink   (input valid, operation, position, coef_re, coef_im, bin_select,
                  output ready);
endinterface

interface rsb_out_if;
  import rsb_pkg::*;
  logic        valid;
  logic        ready;
  logic [63:0] main_sum;
  logic [63:0] extra_sum;
  logic        out_of_range;
  modport source (output valid, main_sum, extra_sum, out_of_range, input ready);
  modport sink   (input valid, main_sum, extra_sum, out_of_range, output ready);
endinterface

// ===== rtl/rsb_div.sv =====
// Restoring divider, one quotient bit per cycle, with a preloaded partial remainder.
// Depends on rsb_pkg (div_req_t).
module rsb_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rsb_pkg::div_req_t req_i,
  output logic              busy_o,
  output logic [63:0]       quo_o,
  output logic [31:0]       rem_o
);
  import rsb_pkg::*;

  logic [6:0]  cnt_q;
  logic [31:0] rem_q, den_q;
  logic [63:0] quo_q;
  logic [32:0] trial;
  logic        ge;

  // remainder stays below the divisor, so trial - den fits 32 bits
  assign trial = {rem_q, quo_q[63]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (req_i.start) begin
      cnt_q <= req_i.steps;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.rem_init;
      den_q <= req_i.den;
      quo_q <= req_i.dividend;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? 32'(trial - {1'b0, den_q}) : trial[31:0];
      quo_q <= {quo_q[62:0], ge};
    end
  end

  assign busy_o = cnt_q != '0;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/rsb_sqrt.sv =====
// Integer square root of a 64-bit value, two radicand bits per cycle.
// Depends on rsb_pkg (sqrt_req_t).
module rsb_sqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rsb_pkg::sqrt_req_t req_i,
  output logic               busy_o,
  output logic [31:0]        root_o
);
  import rsb_pkg::*;

  logic [5:0]  cnt_q;
  logic [63:0] x_q, res_q, one_q;
  logic [63:0] trial;
  logic        ge;

  assign trial = res_q + one_q;
  assign ge    = x_q >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (req_i.start) begin
      cnt_q <= 6'd32;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q   <= req_i.radicand;
      res_q <= '0;
      one_q <= 64'h4000_0000_0000_0000;
    end else if (cnt_q != '0) begin
      if (ge) begin
        x_q   <= x_q - trial;
        res_q <= (res_q >> 1) + one_q;
      end else begin
        res_q <= res_q >> 1;
      end
      one_q <= one_q >> 2;
    end
  end

  assign busy_o = cnt_q != '0;
  assign root_o = res_q[31:0];

endmodule

// ===== rtl/radial_spectrum_binning_unit.sv =====
// Radial spectrum binning: accumulate, read and clear of |k| bins held in one RAM.
// Accumulate uses the shared divider (two index divisions, then the weight division unless w is
// zero or the quotient saturates) and root unit (bin, then weight); an out-of-range bin skips to
// the result. A new item is accepted only in idle, after the result enters the output register.
// Reset: config registers to defaults, bins read as zero via per-entry valid bits; clear
// drops every valid bit at once. Depends on rsb_pkg, rsb_if, rsb_div, rsb_sqrt.
module radial_spectrum_binning_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rsb_pkg::CFG_IW-1:0]   cfg_index_i,
  input  logic [rsb_pkg::CFG_DW-1:0]   cfg_data_i,
  rsb_in_if.sink                       in_ch,
  rsb_out_if.source                    out_ch
);
  import rsb_pkg::*;

  // configuration
  logic [2:0]  mode_q;
  logic [9:0]  grid_len_q, slab_depth_q;
  logic [8:0]  slab_base_q;
  logic [31:0] mass_q, k_scale_q, norm_q;

  state_e state_q, state_d;

  // item working registers
  logic [31:0]       re_q, im_q;
  logic [BIN_AW-1:0] bin_q;
  logic              sel_ok_q;
  logic [9:0]        kx_q, kz_q;
  logic [27:0]       ky_q;
  logic [K2W-1:0]    k2_q;
  logic [63:0]       m2_q, mw_q, main_add_q, extra_add_q;
  logic [47:0]       k2p_q;
  logic [63:0]       res_main_q, res_extra_q;
  logic              res_oor_q;

  // multiply-accumulate
  logic [2:0]   cnt_q;
  logic [127:0] acc_q;
  logic [63:0]  prod_q;
  logic [1:0]   prod_sh_q;
  logic         prod_vld_q;
  logic [31:0]  mul_a, mul_b;
  logic [1:0]   mul_sh;
  logic [63:0]  wide_a, wide_b;
  logic [2:0]   mul_n;
  logic         in_mul, was_mul, mul_issue, acc_clr;

  // bin memory
  logic [127:0]         mem_q [BIN_COUNT];
  logic [BIN_COUNT-1:0] bin_vld_q;
  logic [127:0]         rd_data_q;
  logic                 rd_vld_q;
  logic [BIN_AW-1:0]    rd_addr;
  logic [63:0]          cur_main, cur_extra;

  // output register
  logic        out_valid_q, out_oor_q;
  logic [63:0] out_main_q, out_extra_q;

  // shared units
  div_req_t    div_req;
  sqrt_req_t   sqrt_req;
  logic        div_busy, sqrt_busy;
  logic [63:0] div_quo;
  logic [31:0] div_rem, sqrt_res;

  // index split helpers
  logic [9:0]  lx, tz;
  logic [8:0]  half_n;
  logic [27:0] ky_raw, ky_fold;
  logic [9:0]  kz_raw, kz_fold;
  logic [31:0] re_mag, im_mag;
  logic [63:0] m2_sel;
  logic        in_fire, load_out;

  rsb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .busy_o (div_busy),
    .quo_o  (div_quo),
    .rem_o  (div_rem)
  );

  rsb_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sqrt_req),
    .busy_o (sqrt_busy),
    .root_o (sqrt_res)
  );

  assign in_ch.ready = state_q == S_IDLE;
  assign in_fire     = in_ch.valid && (state_q == S_IDLE);
  assign load_out    = (state_q == S_RESULT) && (!out_valid_q || out_ch.ready);

  assign half_n  = grid_len_q[9:1];
  assign lx      = {1'b0, half_n} + 10'd1;
  assign tz      = (slab_depth_q == '0) ? 10'd1 : slab_depth_q;
  assign ky_raw  = {1'b0, div_quo[26:0]} + {19'b0, slab_base_q};
  assign kz_raw  = div_rem[9:0];

  always_comb begin
    ky_fold = ky_raw;
    if (ky_raw > {19'b0, half_n}) begin
      ky_fold = (ky_raw >= {18'b0, grid_len_q}) ? ky_raw - {18'b0, grid_len_q}
                                                : {18'b0, grid_len_q} - ky_raw;
    end
    kz_fold = (kz_raw > {1'b0, tz[9:1]}) ? tz - kz_raw : kz_raw;
  end

  assign re_mag = re_q[31] ? (~re_q + 32'd1) : re_q;
  assign im_mag = im_q[31] ? (~im_q + 32'd1) : im_q;

  assign cur_main  = rd_vld_q ? rd_data_q[127:64] : '0;
  assign cur_extra = rd_vld_q ? rd_data_q[63:0]   : '0;
  assign rd_addr   = (state_q == S_IDLE) ? BIN_AW'(in_ch.bin_select) : bin_q;

  // next state and unit requests
  always_comb begin
    state_d  = state_q;
    div_req  = '0;
    sqrt_req = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (op_e'(in_ch.operation))
            OP_ACCUM: begin
              div_req.start    = 1'b1;
              div_req.steps    = 7'd27;
              div_req.den      = {22'b0, lx};
              div_req.dividend = {in_ch.position, 37'b0};
              state_d          = S_DIV_X;
            end
            OP_READ:  state_d = S_NRM_M;
            default:  state_d = S_RESULT;
          endcase
        end
      end
      S_DIV_X: begin
        if (!div_busy) begin
          div_req.start    = 1'b1;
          div_req.steps    = 7'd27;
          div_req.den      = {22'b0, tz};
          div_req.dividend = {div_quo[26:0], 37'b0};
          state_d          = S_DIV_Y;
        end
      end
      S_DIV_Y:    if (!div_busy) state_d = S_SQ;
      S_SQ:       if (cnt_q == mul_n) state_d = S_CHK;
      S_CHK: begin
        if (acc_q >= 128'(BIN_LIMIT)) begin
          state_d = S_RESULT;
        end else begin
          sqrt_req.start    = 1'b1;
          sqrt_req.radicand = 64'(acc_q[K2W-1:0]);
          state_d           = S_SQRT_BIN;
        end
      end
      S_SQRT_BIN: if (!sqrt_busy) state_d = S_MAG;
      S_MAG:      if (cnt_q == mul_n) state_d = S_DBL;
      S_DBL:      state_d = S_KSC;
      S_KSC:      if (cnt_q == mul_n) state_d = S_ROOTW;
      S_ROOTW: begin
        sqrt_req.start    = 1'b1;
        sqrt_req.radicand = (64'(acc_q[55:8]) + 64'(mass_q)) << 16;
        state_d           = S_SQRT_W;
      end
      S_SQRT_W:   if (!sqrt_busy) state_d = S_MW;
      S_MW: begin
        if (sqrt_res == '0 || 32'(m2_q[63:48]) >= sqrt_res) begin
          state_d = S_PICK;
        end else begin
          div_req.start    = 1'b1;
          div_req.steps    = 7'd64;
          div_req.rem_init = 32'(m2_q[63:48]);
          div_req.den      = sqrt_res;
          div_req.dividend = {m2_q[47:0], 16'b0};
          state_d          = S_DIV_W;
        end
      end
      S_DIV_W:    if (!div_busy) state_d = S_PICK;
      S_PICK: begin
        case (mode_q)
          MODE_KINETIC, MODE_GRAD_NOK, MODE_POWER, MODE_COUNT: state_d = S_WRITE;
          MODE_GRAD, MODE_GRAD_POT:                            state_d = S_MUL_K;
          MODE_POT:                                            state_d = S_MUL_M;
          default:                                             state_d = S_RESULT;
        endcase
      end
      S_MUL_K:    if (cnt_q == mul_n) state_d = S_KEND;
      S_KEND:     state_d = (mode_q == MODE_GRAD_POT) ? S_MUL_M : S_WRITE;
      S_MUL_M:    if (cnt_q == mul_n) state_d = S_MEND;
      S_MEND:     state_d = S_WRITE;
      S_WRITE:    state_d = S_RESULT;
      S_NRM_M:    if (cnt_q == mul_n) state_d = S_NRM_MEND;
      S_NRM_MEND: state_d = S_NRM_X;
      S_NRM_X:    if (cnt_q == mul_n) state_d = S_NRM_XEND;
      S_NRM_XEND: state_d = S_RESULT;
      S_RESULT:   if (load_out) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // multiplier operand selection: narrow squares and the k scale product, or four 32x32 partials
  always_comb begin
    in_mul = 1'b1;
    mul_n  = 3'd4;
    wide_a = '0;
    wide_b = '0;
    case (state_q)
      S_SQ:    mul_n = 3'd3;
      S_MAG:   mul_n = 3'd2;
      S_KSC:   mul_n = 3'd1;
      S_MUL_K: begin wide_a = mw_q;      wide_b = 64'(k2p_q);  end
      S_MUL_M: begin wide_a = mw_q;      wide_b = 64'(mass_q); end
      S_NRM_M: begin wide_a = cur_main;  wide_b = 64'(norm_q); end
      S_NRM_X: begin wide_a = cur_extra; wide_b = 64'(norm_q); end
      default: in_mul = 1'b0;
    endcase

    case (cnt_q[1:0])
      2'd0:    begin mul_a = wide_a[31:0];  mul_b = wide_b[31:0];  mul_sh = 2'd0; end
      2'd1:    begin mul_a = wide_a[31:0];  mul_b = wide_b[63:32]; mul_sh = 2'd1; end
      2'd2:    begin mul_a = wide_a[63:32]; mul_b = wide_b[31:0];  mul_sh = 2'd1; end
      default: begin mul_a = wide_a[63:32]; mul_b = wide_b[63:32]; mul_sh = 2'd2; end
    endcase

    case (state_q)
      S_SQ: begin
        mul_sh = 2'd0;
        case (cnt_q[1:0])
          2'd0:    mul_a = {22'b0, kx_q};
          2'd1:    mul_a = {4'b0, ky_q};
          default: mul_a = {22'b0, kz_q};
        endcase
        mul_b = mul_a;
      end
      S_MAG: begin
        mul_sh = 2'd0;
        mul_a  = (cnt_q == 3'd0) ? re_mag : im_mag;
        mul_b  = mul_a;
      end
      S_KSC: begin
        mul_sh = 2'd0;
        mul_a  = 32'(k2_q);
        mul_b  = k_scale_q;
      end
      default: ;
    endcase
  end

  assign mul_issue = in_mul && (cnt_q < mul_n);

  always_comb begin
    case (state_q)
      S_SQ, S_MAG, S_KSC, S_MUL_K, S_MUL_M, S_NRM_M, S_NRM_X: was_mul = 1'b1;
      default:                                                was_mul = 1'b0;
    endcase
    case (state_d)
      S_SQ, S_MAG, S_KSC, S_MUL_K, S_MUL_M, S_NRM_M, S_NRM_X: acc_clr = !was_mul;
      default:                                                acc_clr = 1'b0;
    endcase
  end

  assign m2_sel = (mode_q == MODE_COUNT) ? 64'h1_0000_0000 : acc_q[63:0];

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      prod_vld_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      bin_vld_q    <= '0;
      mode_q       <= MODE_POWER;
      grid_len_q   <= 10'd256;
      slab_depth_q <= 10'd256;
      slab_base_q  <= '0;
      mass_q       <= '0;
      k_scale_q    <= 32'd16777216;
      norm_q       <= 32'd65536;
    end else begin
      state_q    <= state_d;
      cnt_q      <= (in_mul && state_d == state_q) ? cnt_q + 3'd1 : 3'd0;
      prod_vld_q <= mul_issue;

      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end

      if (in_fire && op_e'(in_ch.operation) == OP_CLEAR) begin
        bin_vld_q <= '0;
      end else if (state_q == S_WRITE) begin
        bin_vld_q[bin_q] <= 1'b1;
      end

      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MODE:       mode_q       <= cfg_data_i[2:0];
          CFG_GRID_LEN:   grid_len_q   <= cfg_data_i[9:0];
          CFG_SLAB_DEPTH: slab_depth_q <= cfg_data_i[9:0];
          CFG_SLAB_BASE:  slab_base_q  <= cfg_data_i[8:0];
          CFG_MASS:       mass_q       <= cfg_data_i;
          CFG_K_SCALE:    k_scale_q    <= cfg_data_i;
          CFG_NORM:       norm_q       <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q    <= 64'(mul_a) * 64'(mul_b);
    prod_sh_q <= mul_sh;

    if (acc_clr) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      case (prod_sh_q)
        2'd0:    acc_q <= acc_q + 128'(prod_q);
        2'd1:    acc_q <= acc_q + (128'(prod_q) << 32);
        default: acc_q <= acc_q + (128'(prod_q) << 64);
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          re_q        <= in_ch.coef_re;
          im_q        <= in_ch.coef_im;
          bin_q       <= BIN_AW'(in_ch.bin_select);
          sel_ok_q    <= {24'b0, in_ch.bin_select} < 32'(BIN_COUNT);
          res_main_q  <= '0;
          res_extra_q <= '0;
          res_oor_q   <= 1'b0;
        end
      end
      S_DIV_X: if (!div_busy) kx_q <= div_rem[9:0];
      S_DIV_Y: begin
        if (!div_busy) begin
          ky_q <= ky_fold;
          kz_q <= kz_fold;
        end
      end
      S_CHK: begin
        k2_q <= acc_q[K2W-1:0];
        if (acc_q >= 128'(BIN_LIMIT)) res_oor_q <= 1'b1;
      end
      S_SQRT_BIN: if (!sqrt_busy) bin_q <= sqrt_res[BIN_AW-1:0];
      S_DBL: begin
        // kx = 0 and Nyquist columns have no mirrored partner
        if (kx_q == '0 || kx_q == {1'b0, half_n}) begin
          m2_q <= m2_sel;
        end else begin
          m2_q <= sat_add(m2_sel, m2_sel);
        end
      end
      S_ROOTW: k2p_q <= acc_q[55:8];
      S_MW: begin
        // zero root or overflowing quotient: saturate unless m2 itself is zero
        if (sqrt_res == '0 && m2_q == '0) mw_q <= '0;
        else                              mw_q <= '1;
      end
      S_DIV_W: if (!div_busy) mw_q <= div_quo;
      S_PICK: begin
        extra_add_q <= '0;
        case (mode_q)
          MODE_KINETIC, MODE_GRAD_NOK: main_add_q <= mw_q;
          MODE_POWER, MODE_COUNT:      main_add_q <= m2_q;
          default:                     main_add_q <= '0;
        endcase
      end
      S_KEND: main_add_q  <= q16_sat(acc_q);
      S_MEND: extra_add_q <= q16_sat(acc_q);
      S_NRM_MEND: begin
        if (!sel_ok_q)                 res_main_q <= '0;
        else if (mode_q == MODE_COUNT) res_main_q <= cur_main;
        else                           res_main_q <= q16_sat(acc_q);
      end
      S_NRM_XEND: res_extra_q <= sel_ok_q ? q16_sat(acc_q) : '0;
      default: ;
    endcase

    if (load_out) begin
      out_main_q  <= res_main_q;
      out_extra_q <= res_extra_q;
      out_oor_q   <= res_oor_q;
    end
  end

  // bin RAM: one read and one write port, registered read
  always_ff @(posedge clk_i) begin
    if (state_q == S_WRITE) begin
      mem_q[bin_q] <= {sat_add(cur_main, main_add_q), sat_add(cur_extra, extra_add_q)};
    end
    rd_data_q <= mem_q[rd_addr];
    rd_vld_q  <= bin_vld_q[rd_addr];
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.main_sum     = out_main_q;
  assign out_ch.extra_sum    = out_extra_q;
  assign out_ch.out_of_range = out_oor_q;

endmodule
